// File: rtl/bsp_pkg.sv
package bsp_pkg;

  // Configuration register indexes.
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIFF_THRESHOLD = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BLEND_WEIGHT   = 2'd3;

  // Field widths.
  localparam int unsigned PIX_W = 8;
  localparam int unsigned COL_W = 9;
  localparam int unsigned ROW_W = 8;
  localparam int unsigned WGT_W = 9;

  // Update arithmetic: every update is a 16-bit numerator over a 9-bit divisor.
  localparam int unsigned NUM_W = 16;
  localparam int unsigned DIV_W = 9;
  localparam int unsigned QUO_W = 8;
  localparam int unsigned DIV_STAGES = QUO_W / 2;

  localparam int unsigned OUT_DATA_W = 32;

  typedef enum logic [2:0] {
    MODE_COPY = 3'b001,
    MODE_MEAN = 3'b010,
    MODE_EMA  = 3'b100
  } upd_mode_t;

  typedef struct packed {
    upd_mode_t mode;
    logic      ready;
    logic      last;
  } pix_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             ready;
    logic             last;
  } pix_meta_t;

endpackage

// File: rtl/bsp_frame_store.sv
module bsp_frame_store #(
  parameter int unsigned DEPTH = 76800,
  parameter int unsigned AW    = 17
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bsp_pkg::PIX_W-1:0]  wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [bsp_pkg::PIX_W-1:0]  rdata_r
);

  logic [bsp_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: rtl/bsp_seq.sv
module bsp_seq #(
  parameter int unsigned MAX_WIDTH    = 320,
  parameter int unsigned MAX_HEIGHT   = 240,
  parameter int unsigned LEARN_FRAMES = 20,
  parameter int unsigned AW           = 17,
  parameter int unsigned FW           = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       restart,
  input  logic                       step,
  input  logic [bsp_pkg::COL_W-1:0]  cfg_width,
  input  logic [bsp_pkg::ROW_W-1:0]  cfg_height,
  output logic [bsp_pkg::COL_W-1:0]  col,
  output logic [bsp_pkg::ROW_W-1:0]  row,
  output logic [AW-1:0]              addr,
  output logic [FW-1:0]              frames,
  output bsp_pkg::pix_ctl_t          ctl
);

  localparam int unsigned COL_LIM = (1 << bsp_pkg::COL_W) - 1;
  localparam int unsigned ROW_LIM = (1 << bsp_pkg::ROW_W) - 1;
  localparam int unsigned MAX_W_LIM = (MAX_WIDTH > COL_LIM) ? COL_LIM : MAX_WIDTH;
  localparam int unsigned MAX_H_LIM = (MAX_HEIGHT > ROW_LIM) ? ROW_LIM : MAX_HEIGHT;
  localparam logic [bsp_pkg::COL_W-1:0] MAX_W_C = MAX_W_LIM[bsp_pkg::COL_W-1:0];
  localparam logic [bsp_pkg::ROW_W-1:0] MAX_H_C = MAX_H_LIM[bsp_pkg::ROW_W-1:0];
  localparam logic [FW-1:0] LEARN_C    = LEARN_FRAMES[FW-1:0];
  localparam logic [FW-1:0] LEARN_M1_C = LEARN_C - 1'b1;

  logic [bsp_pkg::COL_W-1:0] col_r, col_nxt, w_eff;
  logic [bsp_pkg::ROW_W-1:0] row_r, row_nxt, h_eff;
  logic [AW-1:0]             addr_r, addr_nxt;
  logic [FW-1:0]             frames_r, frames_nxt;
  logic                      col_last, row_last;

  // Out-of-range frame sizes: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (cfg_width == '0) begin
      w_eff = {{(bsp_pkg::COL_W-1){1'b0}}, 1'b1};
    end else if (cfg_width > MAX_W_C) begin
      w_eff = MAX_W_C;
    end else begin
      w_eff = cfg_width;
    end
    if (cfg_height == '0) begin
      h_eff = {{(bsp_pkg::ROW_W-1){1'b0}}, 1'b1};
    end else if (cfg_height > MAX_H_C) begin
      h_eff = MAX_H_C;
    end else begin
      h_eff = cfg_height;
    end
  end

  assign col_last = (col_r == w_eff - 1'b1);
  assign row_last = (row_r == h_eff - 1'b1);

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    addr_nxt   = addr_r;
    frames_nxt = frames_r;
    if (step) begin
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt  = '0;
          addr_nxt = '0;
          if (frames_r != LEARN_C) begin
            frames_nxt = frames_r + 1'b1;
          end
        end else begin
          row_nxt  = row_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end else begin
        col_nxt  = col_r + 1'b1;
        addr_nxt = addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r    <= '0;
      row_r    <= '0;
      addr_r   <= '0;
      frames_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      addr_r   <= addr_nxt;
      frames_r <= frames_nxt;
    end
  end

  assign col    = col_r;
  assign row    = row_r;
  assign addr   = addr_r;
  assign frames = frames_r;

  // The counter saturates at the learning length (blend mode); ready starts a frame earlier.
  always_comb begin
    if (frames_r == '0) begin
      ctl.mode = bsp_pkg::MODE_COPY;
    end else if (frames_r != LEARN_C) begin
      ctl.mode = bsp_pkg::MODE_MEAN;
    end else begin
      ctl.mode = bsp_pkg::MODE_EMA;
    end
    ctl.ready = (frames_r >= LEARN_M1_C);
    ctl.last  = col_last && row_last;
  end

endmodule

// File: rtl/bsp_div_stage.sv
module bsp_div_stage #(
  parameter int unsigned AW = 17
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bsp_pkg::DIV_W-1:0]  in_rem,
  input  logic [bsp_pkg::QUO_W-1:0]  in_num,
  input  logic [bsp_pkg::QUO_W-1:0]  in_quo,
  input  logic [bsp_pkg::DIV_W-1:0]  in_div,
  input  logic [AW-1:0]              in_addr,
  input  bsp_pkg::pix_meta_t         in_meta,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bsp_pkg::DIV_W-1:0]  out_rem,
  output logic [bsp_pkg::QUO_W-1:0]  out_num,
  output logic [bsp_pkg::QUO_W-1:0]  out_quo,
  output logic [bsp_pkg::DIV_W-1:0]  out_div,
  output logic [AW-1:0]              out_addr,
  output bsp_pkg::pix_meta_t         out_meta
);

  // One restoring step: returns {quotient bit, new remainder}.
  function automatic logic [bsp_pkg::DIV_W:0] div_step(
    input logic [bsp_pkg::DIV_W-1:0] rem,
    input logic                      nb,
    input logic [bsp_pkg::DIV_W-1:0] dv
  );
    logic [bsp_pkg::DIV_W:0] sh;
    logic [bsp_pkg::DIV_W:0] df;
    sh = {rem, nb};
    df = sh - {1'b0, dv};
    if (sh >= {1'b0, dv}) begin
      div_step = {1'b1, df[bsp_pkg::DIV_W-1:0]};
    end else begin
      div_step = {1'b0, sh[bsp_pkg::DIV_W-1:0]};
    end
  endfunction

  logic                      v_r;
  logic [bsp_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [bsp_pkg::QUO_W-1:0] num_r, num_nxt;
  logic [bsp_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [bsp_pkg::DIV_W-1:0] div_r;
  logic [AW-1:0]             addr_r;
  bsp_pkg::pix_meta_t        meta_r;
  logic [bsp_pkg::DIV_W:0]   step_a, step_b;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    step_a  = div_step(in_rem, in_num[bsp_pkg::QUO_W-1], in_div);
    step_b  = div_step(step_a[bsp_pkg::DIV_W-1:0], in_num[bsp_pkg::QUO_W-2], in_div);
    rem_nxt = step_b[bsp_pkg::DIV_W-1:0];
    quo_nxt = {in_quo[bsp_pkg::QUO_W-3:0], step_a[bsp_pkg::DIV_W], step_b[bsp_pkg::DIV_W]};
    num_nxt = {in_num[bsp_pkg::QUO_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem_r  <= rem_nxt;
      num_r  <= num_nxt;
      quo_r  <= quo_nxt;
      div_r  <= in_div;
      addr_r <= in_addr;
      meta_r <= in_meta;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_num   = num_r;
  assign out_quo   = quo_r;
  assign out_div   = div_r;
  assign out_addr  = addr_r;
  assign out_meta  = meta_r;

endmodule

// File: rtl/background_subtract_pixel_core.sv
// Throughput: one item per cycle while out_tready is high. The frame store is read
// when a pixel enters and written when it leaves the divider, so a pixel waits while
// an item for the same store entry is still in flight; this happens only for frames
// of 6 pixels or fewer. Reset (rst_n low, synchronous) clears the raster counters,
// learning state and all valid bits, and loads the register defaults; the frame
// store holds no reset state.
module background_subtract_pixel_core #(
  parameter int unsigned MAX_WIDTH    = 320,
  parameter int unsigned MAX_HEIGHT   = 240,
  parameter int unsigned LEARN_FRAMES = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [bsp_pkg::REG_IDX_W-1:0]       cfg_addr,
  input  logic [bsp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // Input stream. in_tdata: [7:0] pixel_value.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bsp_pkg::PIX_W-1:0]           in_tdata,
  // Result stream.
  // out_tdata: [0] changed, [8:1] background_level, [17:9] column, [25:18] line,
  //            [31:26] zero.
  // out_tuser: [0] model_ready. out_tlast: frame_end.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bsp_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast
);

  // Store geometry and learning counter width follow from the parameters.
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW    = $clog2(LEARN_FRAMES + 1);
  localparam int unsigned NDS   = bsp_pkg::DIV_STAGES;
  localparam int unsigned PAD_W = bsp_pkg::OUT_DATA_W - 1 - bsp_pkg::PIX_W
                                  - bsp_pkg::COL_W - bsp_pkg::ROW_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. A write of either frame dimension restarts the
  // model, so the next item begins learning frame 0 again.
  // ---------------------------------------------------------------------------
  logic [bsp_pkg::COL_W-1:0] cfg_width_r;
  logic [bsp_pkg::ROW_W-1:0] cfg_height_r;
  logic [bsp_pkg::PIX_W-1:0] cfg_thresh_r;
  logic [bsp_pkg::WGT_W-1:0] cfg_weight_r;
  logic                      restart;

  assign restart = cfg_we && ((cfg_addr == bsp_pkg::REG_FRAME_WIDTH) ||
                              (cfg_addr == bsp_pkg::REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= 9'd320;
      cfg_height_r <= 8'd240;
      cfg_thresh_r <= 8'd25;
      cfg_weight_r <= 9'd26;
    end else if (cfg_we) begin
      case (cfg_addr)
        bsp_pkg::REG_FRAME_WIDTH:    cfg_width_r  <= cfg_wdata[bsp_pkg::COL_W-1:0];
        bsp_pkg::REG_FRAME_HEIGHT:   cfg_height_r <= cfg_wdata[bsp_pkg::ROW_W-1:0];
        bsp_pkg::REG_DIFF_THRESHOLD: cfg_thresh_r <= cfg_wdata[bsp_pkg::PIX_W-1:0];
        bsp_pkg::REG_BLEND_WEIGHT:   cfg_weight_r <= cfg_wdata[bsp_pkg::WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Raster sequencer: column, line, linear store address and learning state of
  // the next pixel to be accepted.
  // ---------------------------------------------------------------------------
  logic [bsp_pkg::COL_W-1:0] seq_col;
  logic [bsp_pkg::ROW_W-1:0] seq_row;
  logic [AW-1:0]             seq_addr;
  logic [FW-1:0]             seq_frames;
  bsp_pkg::pix_ctl_t         seq_ctl;
  logic                      in_accept;

  bsp_seq #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .LEARN_FRAMES (LEARN_FRAMES),
    .AW           (AW),
    .FW           (FW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .step       (in_accept),
    .cfg_width  (cfg_width_r),
    .cfg_height (cfg_height_r),
    .col        (seq_col),
    .row        (seq_row),
    .addr       (seq_addr),
    .frames     (seq_frames),
    .ctl        (seq_ctl)
  );

  // ---------------------------------------------------------------------------
  // Pipeline control. Each stage loads when it is empty or the stage after it
  // moves on, so bubbles close up even while the output waits.
  // ---------------------------------------------------------------------------
  logic                      s1_v_r, s2_v_r, out_v_r;
  logic                      s1_en, s2_en, out_en;
  logic                      hazard;

  logic                      dv_valid [0:NDS];
  logic                      dv_ready [0:NDS];
  logic [bsp_pkg::DIV_W-1:0] dv_rem   [0:NDS];
  logic [bsp_pkg::QUO_W-1:0] dv_num   [0:NDS];
  logic [bsp_pkg::QUO_W-1:0] dv_quo   [0:NDS];
  logic [bsp_pkg::DIV_W-1:0] dv_div   [0:NDS];
  logic [AW-1:0]             dv_addr  [0:NDS];
  bsp_pkg::pix_meta_t        dv_meta  [0:NDS];

  assign out_en = !out_v_r || out_tready;
  assign s2_en  = !s2_v_r || dv_ready[0];
  assign s1_en  = !s1_v_r || s2_en;

  // A pixel may not read the store while an item for the same entry is still
  // in flight: its read would miss that item's update. The stage that writes
  // this cycle is included, since the store returns old data on a collision.
  logic [AW-1:0] s1_addr_r, s2_addr_r;

  always_comb begin
    hazard = (s1_v_r && (s1_addr_r == seq_addr)) ||
             (s2_v_r && (s2_addr_r == seq_addr));
    for (int j = 1; j <= NDS; j++) begin
      hazard = hazard || (dv_valid[j] && (dv_addr[j] == seq_addr));
    end
  end

  assign in_tready = s1_en && !hazard;
  assign in_accept = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Frame store: read on accept, written with the finished level as the item
  // leaves the last divider stage.
  // ---------------------------------------------------------------------------
  logic                      st_we;
  logic [bsp_pkg::PIX_W-1:0] st_rdata;

  assign st_we = dv_valid[NDS] && out_en;

  bsp_frame_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (st_we),
    .waddr   (dv_addr[NDS]),
    .wdata   (dv_quo[NDS]),
    .re      (in_accept),
    .raddr   (seq_addr),
    .rdata_r (st_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: item held beside the store read data.
  // ---------------------------------------------------------------------------
  logic [FW-1:0]      s1_k_r;
  bsp_pkg::upd_mode_t s1_mode_r;
  bsp_pkg::pix_meta_t s1_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_addr_r       <= seq_addr;
      s1_k_r          <= seq_frames;
      s1_mode_r       <= seq_ctl.mode;
      s1_meta_r.pixel <= in_tdata;
      s1_meta_r.col   <= seq_col;
      s1_meta_r.row   <= seq_row;
      s1_meta_r.ready <= seq_ctl.ready;
      s1_meta_r.last  <= seq_ctl.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: every update becomes numerator / divisor.
  //   copy:  p / 1
  //   mean:  (bg*k + p) / (k+1)
  //   blend: (bg*(256-w) + p*w) / 256
  // The quotient always fits in 8 bits, which the divider relies on.
  // ---------------------------------------------------------------------------
  logic [bsp_pkg::NUM_W-1:0] rd16, k16, p16, wt16, inv16, num_nxt;
  logic [bsp_pkg::DIV_W-1:0] k_ext, wt9, div_nxt;
  logic [bsp_pkg::NUM_W-1:0] s2_num_r;
  logic [bsp_pkg::DIV_W-1:0] s2_div_r;
  bsp_pkg::pix_meta_t        s2_meta_r;

  always_comb begin
    rd16 = {{(bsp_pkg::NUM_W-bsp_pkg::PIX_W){1'b0}}, st_rdata};
    p16  = {{(bsp_pkg::NUM_W-bsp_pkg::PIX_W){1'b0}}, s1_meta_r.pixel};
    k16  = '0;
    k16[FW-1:0] = s1_k_r;
    k_ext = '0;
    k_ext[FW-1:0] = s1_k_r;
    // Weights above one (256) saturate at one.
    wt9   = cfg_weight_r[bsp_pkg::WGT_W-1] ? 9'd256 : cfg_weight_r;
    wt16  = {{(bsp_pkg::NUM_W-bsp_pkg::WGT_W){1'b0}}, wt9};
    inv16 = 16'd256 - wt16;
    case (s1_mode_r)
      bsp_pkg::MODE_COPY: begin
        num_nxt = p16;
        div_nxt = 9'd1;
      end
      bsp_pkg::MODE_MEAN: begin
        num_nxt = rd16 * k16 + p16;
        div_nxt = k_ext + 9'd1;
      end
      bsp_pkg::MODE_EMA: begin
        num_nxt = rd16 * inv16 + p16 * wt16;
        div_nxt = 9'd256;
      end
      default: begin
        num_nxt = p16;
        div_nxt = 9'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_num_r  <= num_nxt;
      s2_div_r  <= div_nxt;
      s2_addr_r <= s1_addr_r;
      s2_meta_r <= s1_meta_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: restoring division, two quotient bits per stage. The upper byte
  // of the numerator is already below the divisor and seeds the remainder.
  // ---------------------------------------------------------------------------
  assign dv_valid[0] = s2_v_r;
  assign dv_rem[0]   = {1'b0, s2_num_r[bsp_pkg::NUM_W-1:bsp_pkg::QUO_W]};
  assign dv_num[0]   = s2_num_r[bsp_pkg::QUO_W-1:0];
  assign dv_quo[0]   = '0;
  assign dv_div[0]   = s2_div_r;
  assign dv_addr[0]  = s2_addr_r;
  assign dv_meta[0]  = s2_meta_r;
  assign dv_ready[NDS] = out_en;

  for (genvar g = 0; g < NDS; g++) begin : g_div
    bsp_div_stage #(
      .AW (AW)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_valid[g]),
      .in_ready  (dv_ready[g]),
      .in_rem    (dv_rem[g]),
      .in_num    (dv_num[g]),
      .in_quo    (dv_quo[g]),
      .in_div    (dv_div[g]),
      .in_addr   (dv_addr[g]),
      .in_meta   (dv_meta[g]),
      .out_valid (dv_valid[g+1]),
      .out_ready (dv_ready[g+1]),
      .out_rem   (dv_rem[g+1]),
      .out_num   (dv_num[g+1]),
      .out_quo   (dv_quo[g+1]),
      .out_div   (dv_div[g+1]),
      .out_addr  (dv_addr[g+1]),
      .out_meta  (dv_meta[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: change test against the updated background.
  // ---------------------------------------------------------------------------
  logic [bsp_pkg::PIX_W-1:0] bg_new, pix_fin, abs_diff;
  logic                      changed_nxt;
  logic                      out_changed_r;
  logic [bsp_pkg::PIX_W-1:0] out_bg_r;
  logic [bsp_pkg::COL_W-1:0] out_col_r;
  logic [bsp_pkg::ROW_W-1:0] out_row_r;
  logic                      out_ready_r;
  logic                      out_last_r;

  always_comb begin
    bg_new      = dv_quo[NDS];
    pix_fin     = dv_meta[NDS].pixel;
    abs_diff    = (bg_new > pix_fin) ? (bg_new - pix_fin) : (pix_fin - bg_new);
    changed_nxt = dv_meta[NDS].ready && (abs_diff > cfg_thresh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= dv_valid[NDS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_changed_r <= changed_nxt;
      out_bg_r      <= bg_new;
      out_col_r     <= dv_meta[NDS].col;
      out_row_r     <= dv_meta[NDS].row;
      out_ready_r   <= dv_meta[NDS].ready;
      out_last_r    <= dv_meta[NDS].last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_row_r, out_col_r, out_bg_r, out_changed_r};
  assign out_tuser  = out_ready_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // The hazard stall must keep a store read away from the entry written
  // in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_we && in_accept && (dv_addr[NDS] == seq_addr)))
    else $error("frame store read and write hit the same entry");

  // A finished division leaves a remainder below its divisor.
  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid[NDS] |-> (dv_rem[NDS] < dv_div[NDS]))
    else $error("divider remainder not below divisor");

  // The linear store address restarts exactly at the first pixel of a frame.
  a_addr_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (seq_addr == '0)) |-> ((seq_col == '0) && (seq_row == '0)))
    else $error("store address zero away from frame origin");
`endif

endmodule
